FILE: hdl/cic_pkg.sv
package cic_pkg;

   localparam int POS_W      = 32;
   localparam int CPL_W      = 32;
   localparam int FRAC_W     = 12;
   localparam int WGT_W      = 13;
   localparam int WXY_W      = 25;
   localparam int INC_W      = 17;
   localparam int INC_LSB    = 20;
   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 32;
   localparam int PROD_W     = 65;
   localparam int WEIGHT_W   = 32;
   localparam int INDEX_W    = 15;
   localparam int STEP_W     = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CPL_W-1:0]  CPL_RESET = 32'd65536;
   localparam logic [WGT_W-1:0]  FRAC_ONE  = 13'd4096;

   localparam logic ACT_DEPOSIT = 1'b0;
   localparam logic ACT_READ    = 1'b1;

   // register index is paddr[2]
   localparam logic CSR_IDX_CPL = 1'b0;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_IDLE = 5'd0;
   localparam step_type STEP_RD   = 5'd21;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_NEXT,
      SEQ_FINISH
   } seq_op_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SCALE,
      MUL_RECIP,
      MUL_PAIR,
      MUL_CORNER
   } mul_op_type;

   typedef struct packed {
      seq_op_type seq;
      step_type   target;
      mul_op_type mul;
      axis_type   axis;
      logic [2:0] corner;
      logic       mem_rd;
   } ctrl_word_type;

   typedef struct packed {
      logic clear_busy;
      logic req_valid;
      logic req_read;
      logic rsp_need;
      logic rsp_free;
   } seq_status_type;

   typedef struct packed {
      logic               action;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_z;
      logic               last_particle;
      logic [INDEX_W-1:0] cell_index;
   } cic_req_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] cell_weight;
      logic                batch_done;
   } cic_rsp_type;

endpackage

FILE: hdl/cic_sequencer.sv
module cic_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  cic_pkg::seq_status_type status,
   output cic_pkg::ctrl_word_type ucw,
   output logic                   req_ready,
   output logic                   rsp_load
);
   import cic_pkg::*;

   step_type step_ff;
   step_type step_in;

   // control store: three scalings, three modulo reductions, four weight pairs,
   // eight corner products, then drain and finish (reads: memory read, finish)
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w.seq    = SEQ_NEXT;
      w.target = STEP_IDLE;
      w.mul    = MUL_NONE;
      w.axis   = AXIS_X;
      w.corner = 3'd0;
      w.mem_rd = 1'b0;
      case (step)
         5'd0: begin
            w.seq    = SEQ_IDLE;
            w.target = STEP_RD;
         end
         5'd1: begin
            w.mul  = MUL_SCALE;
            w.axis = AXIS_X;
         end
         5'd2: begin
            w.mul  = MUL_SCALE;
            w.axis = AXIS_Y;
         end
         5'd3: begin
            w.mul  = MUL_SCALE;
            w.axis = AXIS_Z;
         end
         5'd4: begin
            w.mul  = MUL_RECIP;
            w.axis = AXIS_X;
         end
         5'd5: begin
            w.mul  = MUL_RECIP;
            w.axis = AXIS_Y;
         end
         5'd6: begin
            w.mul  = MUL_RECIP;
            w.axis = AXIS_Z;
         end
         5'd7: begin
            w.mul    = MUL_PAIR;
            w.corner = 3'd0;
         end
         5'd8: begin
            w.mul    = MUL_PAIR;
            w.corner = 3'd1;
         end
         5'd9: begin
            w.mul    = MUL_PAIR;
            w.corner = 3'd2;
         end
         5'd10: begin
            w.mul    = MUL_PAIR;
            w.corner = 3'd3;
         end
         5'd11: begin
            w.mul    = MUL_CORNER;
            w.corner = 3'd0;
         end
         5'd12: begin
            w.mul    = MUL_CORNER;
            w.corner = 3'd1;
         end
         5'd13: begin
            w.mul    = MUL_CORNER;
            w.corner = 3'd2;
         end
         5'd14: begin
            w.mul    = MUL_CORNER;
            w.corner = 3'd3;
         end
         5'd15: begin
            w.mul    = MUL_CORNER;
            w.corner = 3'd4;
         end
         5'd16: begin
            w.mul    = MUL_CORNER;
            w.corner = 3'd5;
         end
         5'd17: begin
            w.mul    = MUL_CORNER;
            w.corner = 3'd6;
         end
         5'd18: begin
            w.mul    = MUL_CORNER;
            w.corner = 3'd7;
         end
         5'd19: begin
            w.seq = SEQ_NEXT;
         end
         5'd20: begin
            w.seq    = SEQ_FINISH;
            w.target = STEP_IDLE;
         end
         5'd21: begin
            w.mem_rd = 1'b1;
         end
         5'd22: begin
            w.seq    = SEQ_FINISH;
            w.target = STEP_IDLE;
         end
         default: begin
            w.seq    = SEQ_FINISH;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   assign ucw = ucode_rom(step_ff);

   always_comb begin
      step_in = step_ff;
      case (ucw.seq)
         SEQ_IDLE: begin
            if (!status.clear_busy && status.req_valid) begin
               step_in = status.req_read ? ucw.target : step_ff + STEP_W'(1);
            end
         end
         SEQ_NEXT: begin
            step_in = step_ff + STEP_W'(1);
         end
         SEQ_FINISH: begin
            if (!status.rsp_need || status.rsp_free) begin
               step_in = ucw.target;
            end
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = (ucw.seq == SEQ_IDLE) && !status.clear_busy;
      rsp_load  = (ucw.seq == SEQ_FINISH) && status.rsp_need && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: hdl/cloud_in_cell_deposit_core.sv
// channel   dir  handshake                  payload
// req       in   req_valid / req_ready      req_data  (cic_pkg::cic_req_type)
// rsp       out  rsp_valid / rsp_ready      rsp_data  (cic_pkg::cic_rsp_type)
// csr       in   psel / penable / pready    paddr, pwdata, prdata (cells_per_length)
//
// a deposit keeps the sequencer busy until its finish step: one shared
// 33x32 multiplier runs 18 products (3 scalings, 3 modulo reductions, 12 weights)
// and the grid memory read-modify-write pipeline drains after that.
// a read does one registered memory read before its finish step.
// after reset the grid is cleared one cell per cycle, all GRID_SIDE^3 cells
// (32768 at the default size); no request is taken until then, csr writes are.
// a result waits in the output register; the sequencer stalls only at its
// finish step when that register is still full.
module cloud_in_cell_deposit_core #(
   parameter int GRID_SIDE = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cic_pkg::cic_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cic_pkg::cic_rsp_type                 rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cic_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [cic_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [cic_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import cic_pkg::*;

   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
   localparam int CELL_W     = $clog2(GRID_SIDE);
   localparam int ADDR_W     = $clog2(GRID_CELLS);
   // floor(h / GRID_SIDE) = (h * RECIP_M) >> RECIP_SH, exact for any 32-bit h
   localparam int RECIP_SH   = 32 + CELL_W;
   localparam logic [MUL_A_W-1:0] RECIP_M = MUL_A_W'(
      ((65'd1 << RECIP_SH) + 65'(GRID_SIDE) - 65'd1) / 65'(GRID_SIDE));

   // configuration
   logic [CPL_W-1:0] cpl_ff, cpl_in;
   logic             csr_wr;

   // request and response
   cic_req_type req_ff, req_in;
   logic        rsp_valid_ff, rsp_valid_in;
   cic_rsp_type rsp_data_ff, rsp_data_in;

   // grid clearing
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // multiplier and write-back
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   mul_op_type         mul_d_ff, mul_d_in;
   axis_type           axis_d_ff, axis_d_in;
   logic [2:0]         corner_d_ff, corner_d_in;

   logic [POS_W-1:0]  h_ff[3], h_in[3];
   logic [FRAC_W-1:0] frac_ff[3], frac_in[3];
   logic [CELL_W-1:0] cell_ff[3], cell_in[3];
   logic [WXY_W-1:0]  wxy_ff[4], wxy_in[4];
   logic [CELL_W-1:0] q_lo;

   // grid update pipeline
   logic              va_ff, va_in;
   logic [ADDR_W-1:0] addr_a_ff, addr_a_in;
   logic [INC_W-1:0]  inc_a_ff, inc_a_in;
   logic              vb_ff, vb_in;
   logic [ADDR_W-1:0] addr_b_ff, addr_b_in;
   logic [INC_W-1:0]  inc_b_ff, inc_b_in;
   logic [CELL_W-1:0] sel_x, sel_y, sel_z;

   logic [WEIGHT_W-1:0] grid_mem_ff[GRID_CELLS];
   logic [WEIGHT_W-1:0] mem_q_ff;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [WEIGHT_W-1:0] wr_data;
   logic [WEIGHT_W:0]   sum;

   logic           in_range;
   logic [ADDR_W-1:0] read_addr;

   ctrl_word_type  ucw;
   seq_status_type status;
   logic           rsp_load;
   logic           req_acc;

   function automatic logic [WGT_W-1:0] axis_weight(input logic [FRAC_W-1:0] frac,
                                                    input logic hi);
      return hi ? WGT_W'(frac) : FRAC_ONE - WGT_W'(frac);
   endfunction

   function automatic logic [CELL_W-1:0] next_cell(input logic [CELL_W-1:0] c);
      return (c == CELL_W'(GRID_SIDE - 1)) ? '0 : c + CELL_W'(1);
   endfunction

   cic_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .ucw       (ucw),
      .req_ready (req_ready),
      .rsp_load  (rsp_load)
   );

   assign req_acc   = req_valid && req_ready;
   assign in_range  = 32'(req_ff.cell_index) < 32'(GRID_CELLS);
   assign read_addr = in_range ? ADDR_W'(req_ff.cell_index) : '0;

   always_comb begin
      status.clear_busy = clr_busy_ff;
      status.req_valid  = req_valid;
      status.req_read   = (req_data.action == ACT_READ);
      status.rsp_need   = (req_ff.action == ACT_READ) || req_ff.last_particle;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // csr port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == CSR_IDX_CPL);
   assign prdata = (paddr[2] == CSR_IDX_CPL) ? cpl_ff : '0;
   assign cpl_in = csr_wr ? pwdata : cpl_ff;

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ucw.mul)
         MUL_SCALE: begin
            mul_a = MUL_A_W'(cpl_ff);
            case (ucw.axis)
               AXIS_X:  mul_b = req_ff.pos_x;
               AXIS_Y:  mul_b = req_ff.pos_y;
               default: mul_b = req_ff.pos_z;
            endcase
         end
         MUL_RECIP: begin
            mul_a = RECIP_M;
            mul_b = h_ff[ucw.axis];
         end
         MUL_PAIR: begin
            mul_a = MUL_A_W'(axis_weight(frac_ff[AXIS_X], ucw.corner[0]));
            mul_b = MUL_B_W'(axis_weight(frac_ff[AXIS_Y], ucw.corner[1]));
         end
         MUL_CORNER: begin
            mul_a = MUL_A_W'(wxy_ff[ucw.corner[1:0]]);
            mul_b = MUL_B_W'(axis_weight(frac_ff[AXIS_Z], ucw.corner[2]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in     = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign mul_d_in    = ucw.mul;
   assign axis_d_in   = ucw.axis;
   assign corner_d_in = ucw.corner;
   assign q_lo        = prod_ff[RECIP_SH +: CELL_W];

   // write-back of the previous product
   always_comb begin
      h_in    = h_ff;
      frac_in = frac_ff;
      cell_in = cell_ff;
      wxy_in  = wxy_ff;
      case (mul_d_ff)
         MUL_SCALE: begin
            h_in[axis_d_ff]    = prod_ff[63:32];
            frac_in[axis_d_ff] = prod_ff[31:20];
         end
         MUL_RECIP: begin
            // remainder fits in CELL_W bits, so low bits of h - q*S suffice
            cell_in[axis_d_ff] = h_ff[axis_d_ff][CELL_W-1:0]
                               - CELL_W'(32'(q_lo) * 32'(GRID_SIDE));
         end
         MUL_PAIR: begin
            wxy_in[corner_d_ff[1:0]] = prod_ff[WXY_W-1:0];
         end
         default: begin
            h_in = h_ff;
         end
      endcase
   end

   // corner address and increment
   always_comb begin
      sel_x     = corner_d_ff[0] ? next_cell(cell_ff[AXIS_X]) : cell_ff[AXIS_X];
      sel_y     = corner_d_ff[1] ? next_cell(cell_ff[AXIS_Y]) : cell_ff[AXIS_Y];
      sel_z     = corner_d_ff[2] ? next_cell(cell_ff[AXIS_Z]) : cell_ff[AXIS_Z];
      va_in     = (mul_d_ff == MUL_CORNER);
      addr_a_in = ADDR_W'(32'(sel_x) * 32'(GRID_SIDE * GRID_SIDE)
                        + 32'(sel_y) * 32'(GRID_SIDE) + 32'(sel_z));
      inc_a_in  = prod_ff[INC_LSB +: INC_W];
      vb_in     = va_ff;
      addr_b_in = addr_a_ff;
      inc_b_in  = inc_a_ff;
   end

   // memory ports
   always_comb begin
      rd_en   = ucw.mem_rd || va_ff;
      rd_addr = ucw.mem_rd ? read_addr : addr_a_ff;
      sum     = {1'b0, mem_q_ff} + (WEIGHT_W + 1)'(inc_b_ff);
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = vb_ff;
         wr_addr = addr_b_ff;
         wr_data = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= grid_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem_ff[wr_addr] <= wr_data;
      end
   end

   // clearing pass
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(GRID_CELLS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // request capture and output register
   always_comb begin
      req_in       = req_acc ? req_data : req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.cell_weight = (req_ff.action == ACT_READ && in_range) ? mem_q_ff : '0;
         rsp_data_in.batch_done  = (req_ff.action == ACT_DEPOSIT);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpl_ff       <= CPL_RESET;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         mul_d_ff     <= MUL_NONE;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cpl_ff       <= cpl_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         mul_d_ff     <= mul_d_in;
         va_ff        <= va_in;
         vb_ff        <= vb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
      axis_d_ff   <= axis_d_in;
      corner_d_ff <= corner_d_in;
      h_ff        <= h_in;
      frac_ff     <= frac_in;
      cell_ff     <= cell_in;
      wxy_ff      <= wxy_in;
      addr_a_ff   <= addr_a_in;
      inc_a_ff    <= inc_a_in;
      addr_b_ff   <= addr_b_in;
      inc_b_ff    <= inc_b_in;
   end

endmodule
